[hdl/pwfp_pkg.sv]
// Package for the protobuf wire-format field parser.
// Holds the item structs, the parse phase type and the record, error and wire codes.
// No dependencies.
package pwfp_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_buffer;
	} byte_item_t;

	typedef struct packed {
		logic [1:0]  record_kind;
		logic [31:0] field_number;
		logic [2:0]  wire_kind;
		logic [63:0] field_value;
		logic [7:0]  payload_byte;
		logic        last_payload;
		logic [2:0]  error_code;
		logic        buffer_done;
	} record_item_t;

	typedef enum logic [2:0] {
		PH_TAG     = 3'd0,
		PH_VARINT  = 3'd1,
		PH_FIX64   = 3'd2,
		PH_LEN     = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_FIX32   = 3'd5
	} phase_t;

	localparam logic [1:0] REC_FIELD   = 2'd0;
	localparam logic [1:0] REC_PAYLOAD = 2'd1;
	localparam logic [1:0] REC_ERROR   = 2'd2;
	localparam logic [1:0] REC_RSVD    = 2'd3;

	localparam logic [2:0] ERR_NONE         = 3'd0;
	localparam logic [2:0] ERR_TRUNC_VARINT = 3'd1;
	localparam logic [2:0] ERR_TRUNC_FIX32  = 3'd2;
	localparam logic [2:0] ERR_TRUNC_FIX64  = 3'd3;
	localparam logic [2:0] ERR_TRUNC_LEN    = 3'd4;
	localparam logic [2:0] ERR_UNKNOWN_WIRE = 3'd5;

	localparam logic [2:0] WK_VARINT = 3'd0;
	localparam logic [2:0] WK_FIX64  = 3'd1;
	localparam logic [2:0] WK_LEN    = 3'd2;
	localparam logic [2:0] WK_FIX32  = 3'd5;

	localparam logic [6:0] SHIFT_LIMIT = 7'd64;
	localparam logic [6:0] VARINT_STEP = 7'd7;
	localparam logic [6:0] FIXED_STEP  = 7'd8;
	localparam logic [63:0] FIX32_BYTES = 64'd4;
	localparam logic [63:0] FIX64_BYTES = 64'd8;

endpackage

[hdl/protobuf_wire_field_parser.sv]
// Top level of the protobuf wire-format field parser.
// Depends on pwfp_pkg.
//
// Takes one message byte per item and emits at most one record per byte: a field record
// once a value or length is complete, one record per passed payload byte, or an error.
// It accepts a byte in every cycle unless byte_stall holds it off; a record appears in
// the cycle after its byte is accepted, in the result register. The rate is set by the
// parse-state registers, which each accepted byte updates. While a record waits under
// stall, the next byte is held off only if that record is not taken in the same cycle.
module protobuf_wire_field_parser (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_stall,
	input  pwfp_pkg::byte_item_t   byte_item,
	output logic                  record_valid,
	input  logic                  record_stall,
	output pwfp_pkg::record_item_t record_item
);
	import pwfp_pkg::*;

	phase_t       phase_q, phase_n;
	logic [63:0]  acc_q, acc_n;
	logic [6:0]   shift_q, shift_n;
	logic [31:0]  fn_q, fn_n;
	logic [2:0]   wk_q, wk_n;
	logic [63:0]  rem_q, rem_n;
	logic         discard_q, discard_n;
	logic         record_valid_q;
	record_item_t record_item_q;

	logic         accept;
	logic [7:0]   b;
	logic         eob;
	logic         cont;
	logic [63:0]  acc_var, acc_fix;
	logic [6:0]   shift_var;
	logic [31:0]  tag_fn, cur_fn;
	logic [2:0]   tag_wk, cur_wk;
	logic [63:0]  rem_dec, rem_fix_dec;
	logic         restart;
	logic         res_valid;
	record_item_t res;

	assign byte_stall = record_valid_q && record_stall;
	assign accept     = byte_valid && !byte_stall;
	assign b          = byte_item.data_byte;
	assign eob        = byte_item.end_of_buffer;
	assign cont       = b[7];

	assign acc_var   = (shift_q < SHIFT_LIMIT) ?
		(acc_q | ({57'd0, b[6:0]} << shift_q[5:0])) : acc_q;
	assign shift_var = (shift_q < SHIFT_LIMIT) ? shift_q + VARINT_STEP : shift_q;
	assign acc_fix   = (shift_q < SHIFT_LIMIT) ?
		(acc_q | ({56'd0, b} << shift_q[5:0])) : acc_q;
	assign tag_fn    = acc_var[34:3];
	assign tag_wk    = acc_var[2:0];
	assign cur_fn    = (phase_q == PH_TAG && !cont) ? tag_fn : fn_q;
	assign cur_wk    = (phase_q == PH_TAG && !cont) ? tag_wk : wk_q;
	assign rem_dec     = rem_q - 64'd1;
	assign rem_fix_dec = (rem_q != 64'd0) ? rem_dec : 64'd0;

	always_comb begin
		res_valid        = 1'b0;
		res.record_kind  = REC_FIELD;
		res.field_number = cur_fn;
		res.wire_kind    = cur_wk;
		res.field_value  = 64'd0;
		res.payload_byte = 8'd0;
		res.last_payload = 1'b0;
		res.error_code   = ERR_NONE;
		res.buffer_done  = eob;
		if (!discard_q) begin
			unique case (phase_q)
				PH_TAG: begin
					if (cont) begin
						if (eob) begin
							res_valid      = 1'b1;
							res.record_kind = REC_ERROR;
							res.error_code  = ERR_TRUNC_VARINT;
						end
					end else begin
						case (tag_wk)
							WK_VARINT, WK_LEN: begin
								res_valid      = eob;
								res.record_kind = REC_ERROR;
								res.error_code  = ERR_TRUNC_VARINT;
							end
							WK_FIX64: begin
								res_valid      = eob;
								res.record_kind = REC_ERROR;
								res.error_code  = ERR_TRUNC_FIX64;
							end
							WK_FIX32: begin
								res_valid      = eob;
								res.record_kind = REC_ERROR;
								res.error_code  = ERR_TRUNC_FIX32;
							end
							default: begin
								res_valid      = 1'b1;
								res.record_kind = REC_ERROR;
								res.error_code  = ERR_UNKNOWN_WIRE;
							end
						endcase
					end
				end
				PH_VARINT: begin
					if (cont) begin
						res_valid      = eob;
						res.record_kind = REC_ERROR;
						res.error_code  = ERR_TRUNC_VARINT;
					end else begin
						res_valid       = 1'b1;
						res.field_value = acc_var;
					end
				end
				PH_LEN: begin
					if (cont) begin
						res_valid      = eob;
						res.record_kind = REC_ERROR;
						res.error_code  = ERR_TRUNC_VARINT;
					end else if (acc_var != 64'd0 && eob) begin
						res_valid      = 1'b1;
						res.record_kind = REC_ERROR;
						res.error_code  = ERR_TRUNC_LEN;
					end else begin
						res_valid       = 1'b1;
						res.field_value = acc_var;
					end
				end
				PH_PAYLOAD: begin
					res_valid = 1'b1;
					if (rem_dec != 64'd0 && eob) begin
						res.record_kind = REC_ERROR;
						res.error_code  = ERR_TRUNC_LEN;
					end else begin
						res.record_kind  = REC_PAYLOAD;
						res.payload_byte = b;
						res.last_payload = (rem_dec == 64'd0);
					end
				end
				PH_FIX32, PH_FIX64: begin
					if (rem_fix_dec == 64'd0) begin
						res_valid       = 1'b1;
						res.field_value = acc_fix;
					end else if (eob) begin
						res_valid      = 1'b1;
						res.record_kind = REC_ERROR;
						res.error_code  = (phase_q == PH_FIX32) ? ERR_TRUNC_FIX32 :
							ERR_TRUNC_FIX64;
					end
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_comb begin
		phase_n   = phase_q;
		acc_n     = acc_q;
		shift_n   = shift_q;
		fn_n      = fn_q;
		wk_n      = wk_q;
		rem_n     = rem_q;
		discard_n = discard_q;
		restart   = 1'b0;
		if (discard_q) begin
			restart = eob;
		end else begin
			unique case (phase_q)
				PH_TAG: begin
					acc_n   = acc_var;
					shift_n = shift_var;
					if (cont) begin
						restart = eob;
					end else begin
						fn_n    = tag_fn;
						wk_n    = tag_wk;
						acc_n   = 64'd0;
						shift_n = 7'd0;
						restart = eob;
						case (tag_wk)
							WK_VARINT: phase_n = PH_VARINT;
							WK_LEN:    phase_n = PH_LEN;
							WK_FIX64: begin
								phase_n = PH_FIX64;
								rem_n   = FIX64_BYTES;
							end
							WK_FIX32: begin
								phase_n = PH_FIX32;
								rem_n   = FIX32_BYTES;
							end
							default:   restart = 1'b1;
						endcase
					end
				end
				PH_VARINT: begin
					acc_n   = acc_var;
					shift_n = shift_var;
					restart = !cont || eob;
				end
				PH_LEN: begin
					acc_n   = acc_var;
					shift_n = shift_var;
					if (cont) begin
						restart = eob;
					end else if (acc_var == 64'd0 || eob) begin
						restart = 1'b1;
					end else begin
						acc_n   = 64'd0;
						shift_n = 7'd0;
						rem_n   = acc_var;
						phase_n = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					rem_n   = rem_dec;
					restart = (rem_dec == 64'd0) || eob;
				end
				PH_FIX32, PH_FIX64: begin
					acc_n   = acc_fix;
					shift_n = shift_q + FIXED_STEP;
					rem_n   = rem_fix_dec;
					restart = (rem_fix_dec == 64'd0) || eob;
				end
				default: restart = 1'b1;
			endcase
		end
		if (restart) begin
			phase_n   = PH_TAG;
			acc_n     = 64'd0;
			shift_n   = 7'd0;
			fn_n      = 32'd0;
			wk_n      = 3'd0;
			rem_n     = 64'd0;
			discard_n = 1'b0;
		end
		if (!discard_q && phase_q == PH_TAG && !cont && !eob &&
			tag_wk != WK_VARINT && tag_wk != WK_LEN &&
			tag_wk != WK_FIX64 && tag_wk != WK_FIX32) begin
			discard_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_TAG;
			acc_q     <= 64'd0;
			shift_q   <= 7'd0;
			fn_q      <= 32'd0;
			wk_q      <= 3'd0;
			rem_q     <= 64'd0;
			discard_q <= 1'b0;
		end else if (accept) begin
			phase_q   <= phase_n;
			acc_q     <= acc_n;
			shift_q   <= shift_n;
			fn_q      <= fn_n;
			wk_q      <= wk_n;
			rem_q     <= rem_n;
			discard_q <= discard_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_valid_q <= 1'b0;
		end else if (accept) begin
			record_valid_q <= res_valid;
		end else if (!record_stall) begin
			record_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) begin
			record_item_q <= res;
		end
	end

	assign record_valid = record_valid_q;
	assign record_item  = record_item_q;

endmodule

[hdl/pwfp_checker.sv]
// Port checker for the protobuf wire-format field parser, bound to the top level.
// Depends on pwfp_pkg and protobuf_wire_field_parser.
module pwfp_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_stall,
	input logic                  record_valid,
	input logic                  record_stall,
	input pwfp_pkg::record_item_t record_item
);
	import pwfp_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_stall |=> record_valid && $stable(record_item))
		else $error("stalled record item changed");

	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_stall |-> byte_stall)
		else $error("byte item taken while record item held");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid |-> record_item.record_kind != REC_RSVD)
		else $error("reserved record kind");

	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_item.record_kind == REC_ERROR |->
		record_item.field_value == 64'd0 && record_item.payload_byte == 8'd0 &&
		!record_item.last_payload && record_item.error_code != ERR_NONE)
		else $error("malformed error item");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		record_valid && record_item.last_payload |->
		record_item.record_kind == REC_PAYLOAD && record_item.wire_kind == WK_LEN)
		else $error("last payload flag on wrong item");

endmodule

bind protobuf_wire_field_parser pwfp_checker u_pwfp_checker (.*);
